>>> src/u8d_pkg.sv
// Shared types and constants of the UTF-8 code point decoder.
package u8d_pkg;

  // Input item as seen on the push side
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic [20:0] code_point;
    logic        was_replaced;
    logic        run_last;
    logic        string_last;
  } out_item_t;

  // Classified item between front and back; len_code is sequence length minus one
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
    logic [1:0] len_code;
  } cls_item_t;

  // Sequence length codes
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  // Byte ranges
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] LEAD2_MIN   = 8'hC0;
  localparam logic [7:0] LEAD_OK_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD_SURR   = 8'hED;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] E0_B1_MIN   = 8'hA0;
  localparam logic [7:0] ED_B1_MAX   = 8'h9F;
  localparam logic [7:0] F0_B1_MIN   = 8'h90;
  localparam logic [7:0] F4_B1_MAX   = 8'h8F;

  // Code point constants
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;

endpackage

>>> src/utf8_code_point_decoder_core.sv
// Top level of the UTF-8 to code point decoder.
// Bytes enter through a queue interface (push/full) and code points leave
// through one (empty/pop). A front end tags each byte with the sequence
// length it announces and queues it; a back end keeps up to four pending
// bytes and runs one decode step per cycle while the result queue has
// room, each step giving at most one code point. A byte that yields zero
// or one result does not hold up the next one, so well-formed text streams
// at one byte per cycle on the same condition; a byte that completes k
// results (after a rescan of an invalid sequence, or at a string end)
// keeps the back end busy, taking no new byte, until all k are given, at
// most four. A byte passes through the input queue and is decoded as the
// back end takes it; its results are registered in the result queue.
module utf8_code_point_decoder_core #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  u8d_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output u8d_pkg::out_item_t out_item
);

  u8d_pkg::cls_item_t q_item;
  logic               q_empty;
  logic               q_pop;

  u8d_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  u8d_back #(
    .DEPTH (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

>>> src/u8d_fifo.sv
// Small register-based FIFO with count, used on both sides of the decoder.
module u8d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/u8d_front.sv
// Front end: accepts bytes, tags each with its sequence length, queues them.
module u8d_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  u8d_pkg::in_item_t   in_item,
  output u8d_pkg::cls_item_t  q_item,
  output logic                q_empty,
  input  logic                q_pop
);

  u8d_pkg::cls_item_t cls;

  // Length of the sequence a byte would announce as a lead byte
  function automatic logic [1:0] len_code_of(input logic [7:0] b);
    logic [1:0] code;
    if (b < u8d_pkg::LEAD2_MIN || b > u8d_pkg::LEAD_MAX) begin
      code = u8d_pkg::LEN_1;
    end else if (b < u8d_pkg::LEAD3_MIN) begin
      code = u8d_pkg::LEN_2;
    end else if (b < u8d_pkg::LEAD4_MIN) begin
      code = u8d_pkg::LEN_3;
    end else begin
      code = u8d_pkg::LEN_4;
    end
    return code;
  endfunction

  // Classify on the way in
  always_comb begin
    cls.data_byte     = in_item.data_byte;
    cls.end_of_string = in_item.end_of_string;
    cls.len_code      = len_code_of(in_item.data_byte);
  end

  u8d_fifo #(
    .WIDTH ($bits(u8d_pkg::cls_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .full    (full),
    .empty   (q_empty)
  );

endmodule

>>> src/u8d_back.sv
// Back end: pending byte buffer, one decode step per cycle while the result queue has room, result queue.
module u8d_back #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  u8d_pkg::cls_item_t  q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output u8d_pkg::out_item_t  out_item
);

  // Pending bytes with their length codes
  logic [7:0] buf_r [4];
  logic [7:0] buf_nxt [4];
  logic [1:0] len_r [4];
  logic [1:0] len_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       eos_r, eos_nxt;
  logic       busy_r, busy_nxt;

  logic               res_full;
  logic               take;
  logic               emit;
  u8d_pkg::out_item_t res;

  // Well-formedness of a complete sequence starting at b0
  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [1:0] code);
    logic ok;
    logic b2_ok, b3_ok;
    b2_ok = (b2 >= u8d_pkg::CONT_MIN) && (b2 <= u8d_pkg::CONT_MAX);
    b3_ok = (b3 >= u8d_pkg::CONT_MIN) && (b3 <= u8d_pkg::CONT_MAX);
    if (b0 >= u8d_pkg::CONT_MIN && b0 < u8d_pkg::LEAD_OK_MIN) begin
      ok = 1'b0;
    end else if (b0 > u8d_pkg::LEAD_MAX) begin
      ok = 1'b0;
    end else if (code == u8d_pkg::LEN_1) begin
      ok = 1'b1;
    end else if (code == u8d_pkg::LEN_3 && !b2_ok) begin
      ok = 1'b0;
    end else if (code == u8d_pkg::LEN_4 && !(b2_ok && b3_ok)) begin
      ok = 1'b0;
    end else begin
      unique case (b0)
        u8d_pkg::LEAD3_MIN: ok = (b1 >= u8d_pkg::E0_B1_MIN) && (b1 <= u8d_pkg::CONT_MAX);
        u8d_pkg::LEAD_SURR: ok = (b1 >= u8d_pkg::CONT_MIN) && (b1 <= u8d_pkg::ED_B1_MAX);
        u8d_pkg::LEAD4_MIN: ok = (b1 >= u8d_pkg::F0_B1_MIN) && (b1 <= u8d_pkg::CONT_MAX);
        u8d_pkg::LEAD_MAX:  ok = (b1 >= u8d_pkg::CONT_MIN) && (b1 <= u8d_pkg::F4_B1_MAX);
        default:            ok = (b1 >= u8d_pkg::CONT_MIN) && (b1 <= u8d_pkg::CONT_MAX);
      endcase
    end
    return ok;
  endfunction

  // Payload bits of the sequence
  function automatic logic [20:0] seq_cp(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [1:0] code);
    logic [20:0] cp;
    unique case (code)
      u8d_pkg::LEN_1: cp = {14'd0, b0[6:0]};
      u8d_pkg::LEN_2: cp = {10'd0, b0[4:0], b1[5:0]};
      u8d_pkg::LEN_3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      u8d_pkg::LEN_4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:        cp = '0;
    endcase
    return cp;
  endfunction

  assign take  = !busy_r && !q_empty && !res_full;
  assign q_pop = take;

  // One decode step on the buffer, with the incoming byte appended when taken
  always_comb begin
    logic [7:0]  v_b [4];
    logic [1:0]  v_l [4];
    logic [2:0]  c;
    logic [2:0]  n;
    logic [2:0]  d;
    logic [2:0]  rem;
    logic [2:0]  n_next;
    logic        e;
    logic        ok;
    logic        more;
    logic [20:0] cp;

    for (int i = 0; i < 4; i++) begin
      if (take && cnt_r == 3'(i)) begin
        v_b[i] = q_item.data_byte;
        v_l[i] = q_item.len_code;
      end else begin
        v_b[i] = buf_r[i];
        v_l[i] = len_r[i];
      end
    end
    c      = take ? cnt_r + 3'd1 : cnt_r;
    e      = take ? q_item.end_of_string : eos_r;
    n      = {1'b0, v_l[0]} + 3'd1;
    ok     = seq_ok(v_b[0], v_b[1], v_b[2], v_b[3], v_l[0]);
    cp     = seq_cp(v_b[0], v_b[1], v_b[2], v_b[3], v_l[0]);
    d      = ok ? n : 3'd1;
    rem    = c - d;
    n_next = {1'b0, v_l[d[1:0]]} + 3'd1;
    more   = (rem != 3'd0) && (e || rem >= n_next);

    emit     = 1'b0;
    res      = '0;
    cnt_nxt  = cnt_r;
    eos_nxt  = eos_r;
    busy_nxt = busy_r;
    for (int i = 0; i < 4; i++) begin
      buf_nxt[i] = buf_r[i];
      len_nxt[i] = len_r[i];
    end

    if (!res_full && (busy_r || take)) begin
      eos_nxt = e;
      if (c != 3'd0 && c >= n) begin
        // Complete sequence at the front: one result, drop it or its lead byte
        emit = 1'b1;
        if (!ok || cp > u8d_pkg::CP_MAX ||
            (cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI)) begin
          res.code_point   = u8d_pkg::CP_REPLACEMENT;
          res.was_replaced = 1'b1;
        end else begin
          res.code_point   = cp;
          res.was_replaced = 1'b0;
        end
        res.run_last    = !more;
        res.string_last = !more && e;
        unique case (d)
          3'd1: begin
            for (int i = 0; i < 3; i++) begin
              buf_nxt[i] = v_b[i+1];
              len_nxt[i] = v_l[i+1];
            end
          end
          3'd2: begin
            for (int i = 0; i < 2; i++) begin
              buf_nxt[i] = v_b[i+2];
              len_nxt[i] = v_l[i+2];
            end
          end
          3'd3: begin
            buf_nxt[0] = v_b[3];
            len_nxt[0] = v_l[3];
          end
          default: ;
        endcase
        cnt_nxt  = rem;
        busy_nxt = more;
      end else if (e) begin
        // String ends inside an unfinished sequence
        emit             = (c != 3'd0);
        res.code_point   = u8d_pkg::CP_REPLACEMENT;
        res.was_replaced = 1'b1;
        res.run_last     = 1'b1;
        res.string_last  = 1'b1;
        cnt_nxt          = 3'd0;
        busy_nxt         = 1'b0;
      end else begin
        // Wait for more bytes
        for (int i = 0; i < 4; i++) begin
          buf_nxt[i] = v_b[i];
          len_nxt[i] = v_l[i];
        end
        cnt_nxt  = c;
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      eos_r  <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      eos_r  <= eos_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Pending bytes, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      buf_r[i] <= buf_nxt[i];
      len_r[i] <= len_nxt[i];
    end
  end

  u8d_fifo #(
    .WIDTH ($bits(u8d_pkg::out_item_t)),
    .DEPTH (DEPTH)
  ) u_results (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (emit),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (out_item),
    .full    (res_full),
    .empty   (empty)
  );

endmodule
